// ----- hdl/yrc_pkg.sv -----
// shared types, constants and helpers for the yuyv to rgb converter
package yrc_pkg;

    localparam int PIX_W  = 8;
    localparam int CHR_W  = PIX_W + 1;
    localparam int TERM_W = 17;
    localparam int SUM_W  = 18;

    localparam logic signed [TERM_W-1:0] COEF_RV = 17'sd359;
    localparam logic signed [TERM_W-1:0] COEF_GU = 17'sd88;
    localparam logic signed [TERM_W-1:0] COEF_GV = 17'sd183;
    localparam logic signed [TERM_W-1:0] COEF_BU = 17'sd454;
    localparam logic [PIX_W-1:0]         PIX_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_red;
        logic             frame_end;
    } yrc_macro_t;

    typedef struct packed {
        logic [PIX_W-1:0]         luma_first;
        logic [PIX_W-1:0]         luma_second;
        logic signed [TERM_W-1:0] rv;
        logic signed [TERM_W-1:0] gu;
        logic signed [TERM_W-1:0] gv;
        logic signed [TERM_W-1:0] bu;
        logic                     gray;
        logic                     frame_end;
    } yrc_terms_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] r0;
        logic signed [SUM_W-1:0] g0;
        logic signed [SUM_W-1:0] b0;
        logic signed [SUM_W-1:0] r1;
        logic signed [SUM_W-1:0] g1;
        logic signed [SUM_W-1:0] b1;
        logic                    frame_end;
    } yrc_sums_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] red_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] blue_second;
        logic             frame_end;
    } yrc_rgb_t;

    // offset binary to two's complement
    function automatic logic signed [CHR_W-1:0] chroma_signed(input logic [PIX_W-1:0] c);
        return $signed({~c[PIX_W-1], ~c[PIX_W-1], c[PIX_W-2:0]});
    endfunction

    // floor divide by 256 and clamp to 0..255
    function automatic logic [PIX_W-1:0] shift_clamp(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] res;
        priority if (s[SUM_W-1])
            res = '0;
        else if (s[SUM_W-2])
            res = PIX_MAX;
        else
            res = s[SUM_W-3:SUM_W-3-PIX_W+1];
        return res;
    endfunction

endpackage

// ----- hdl/yrc_chroma_stage.sv -----
// stage one: chroma offset removal and coefficient products
module yrc_chroma_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  yrc_pkg::yrc_macro_t in_data,
    input  logic                gray,
    output logic                out_valid,
    input  logic                out_ready,
    output yrc_pkg::yrc_terms_t out_data
);

    logic                                 valid_reg;
    yrc_pkg::yrc_terms_t                  data_reg;
    yrc_pkg::yrc_terms_t                  data_next;
    logic signed [yrc_pkg::TERM_W-1:0]    u_ext;
    logic signed [yrc_pkg::TERM_W-1:0]    v_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        u_ext = yrc_pkg::TERM_W'(yrc_pkg::chroma_signed(in_data.chroma_blue));
        v_ext = yrc_pkg::TERM_W'(yrc_pkg::chroma_signed(in_data.chroma_red));
        data_next.luma_first  = in_data.luma_first;
        data_next.luma_second = in_data.luma_second;
        data_next.rv          = yrc_pkg::TERM_W'(v_ext * yrc_pkg::COEF_RV);
        data_next.gu          = yrc_pkg::TERM_W'(u_ext * yrc_pkg::COEF_GU);
        data_next.gv          = yrc_pkg::TERM_W'(v_ext * yrc_pkg::COEF_GV);
        data_next.bu          = yrc_pkg::TERM_W'(u_ext * yrc_pkg::COEF_BU);
        data_next.gray        = gray;
        data_next.frame_end   = in_data.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ----- hdl/yrc_sum_stage.sv -----
// stage two: luma scaling plus chroma terms, gray mode bypass
module yrc_sum_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  yrc_pkg::yrc_terms_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output yrc_pkg::yrc_sums_t  out_data
);

    logic                                valid_reg;
    yrc_pkg::yrc_sums_t                  data_reg;
    yrc_pkg::yrc_sums_t                  data_next;
    logic signed [yrc_pkg::SUM_W-1:0]    ys0;
    logic signed [yrc_pkg::SUM_W-1:0]    ys1;
    logic signed [yrc_pkg::SUM_W-1:0]    rv;
    logic signed [yrc_pkg::SUM_W-1:0]    gt;
    logic signed [yrc_pkg::SUM_W-1:0]    bu;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        ys0 = $signed({2'b00, in_data.luma_first, 8'h00});
        ys1 = $signed({2'b00, in_data.luma_second, 8'h00});
        rv  = yrc_pkg::SUM_W'(in_data.rv);
        gt  = yrc_pkg::SUM_W'(in_data.gu) + yrc_pkg::SUM_W'(in_data.gv);
        bu  = yrc_pkg::SUM_W'(in_data.bu);
        if (in_data.gray)
        begin
            data_next.r0 = ys0;
            data_next.g0 = ys0;
            data_next.b0 = ys0;
            data_next.r1 = ys1;
            data_next.g1 = ys1;
            data_next.b1 = ys1;
        end
        else
        begin
            data_next.r0 = ys0 + rv;
            data_next.g0 = ys0 - gt;
            data_next.b0 = ys0 + bu;
            data_next.r1 = ys1 + rv;
            data_next.g1 = ys1 - gt;
            data_next.b1 = ys1 + bu;
        end
        data_next.frame_end = in_data.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ----- hdl/yrc_clamp_stage.sv -----
// stage three: shift, clamp and output register
module yrc_clamp_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  yrc_pkg::yrc_sums_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output yrc_pkg::yrc_rgb_t  out_data
);

    logic              valid_reg;
    yrc_pkg::yrc_rgb_t data_reg;
    yrc_pkg::yrc_rgb_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.red_first    = yrc_pkg::shift_clamp(in_data.r0);
        data_next.green_first  = yrc_pkg::shift_clamp(in_data.g0);
        data_next.blue_first   = yrc_pkg::shift_clamp(in_data.b0);
        data_next.red_second   = yrc_pkg::shift_clamp(in_data.r1);
        data_next.green_second = yrc_pkg::shift_clamp(in_data.g1);
        data_next.blue_second  = yrc_pkg::shift_clamp(in_data.b1);
        data_next.frame_end    = in_data.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ----- hdl/yuyv_to_rgb_converter.sv -----
// top level: yuyv 4:2:2 macropixel to two rgb888 pixels, bt.601
//
// Input channel (in_valid/in_ready) takes one macropixel per beat: two luma
// bytes, shared U and V bytes in offset binary, and a frame end flag.
// Output channel (out_valid/out_ready) gives two rgb888 pixels per beat plus
// the frame end flag copied through.
// cfg_wr_en/cfg_wr_data write the gray_only bit; when set, each luma byte is
// copied to all three channels of its pixel. Write it only while idle.
// Each input beat is registered in turn on its way to output valid: chroma
// products, luma sums, then shift and clamp into the output register.
// Throughput is one macropixel per cycle while out_ready is high; each stage
// has its own valid bit and ready is passed back stage by stage.
// When the receiver stalls, the output register holds; earlier stages keep
// filling until each is full, so up to three beats are held in flight and
// none is lost or repeated.
// Reset clears all valid bits and gray_only; the block is ready as soon as
// reset is released.
module yuyv_to_rgb_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] luma_first,
    input  logic [7:0] chroma_blue,
    input  logic [7:0] luma_second,
    input  logic [7:0] chroma_red,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red_first,
    output logic [7:0] green_first,
    output logic [7:0] blue_first,
    output logic [7:0] red_second,
    output logic [7:0] green_second,
    output logic [7:0] blue_second,
    output logic       frame_end_out
);

    logic                gray_only_reg;
    yrc_pkg::yrc_macro_t macro_in;
    yrc_pkg::yrc_terms_t terms;
    yrc_pkg::yrc_sums_t  sums;
    yrc_pkg::yrc_rgb_t   rgb;
    logic                s1_valid;
    logic                s1_ready;
    logic                s2_valid;
    logic                s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gray_only_reg <= 1'b0;
        else if (cfg_wr_en)
            gray_only_reg <= cfg_wr_data;
    end

    assign macro_in.luma_first  = luma_first;
    assign macro_in.chroma_blue = chroma_blue;
    assign macro_in.luma_second = luma_second;
    assign macro_in.chroma_red  = chroma_red;
    assign macro_in.frame_end   = frame_end;

    yrc_chroma_stage u_chroma (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (macro_in),
        .gray      (gray_only_reg),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (terms)
    );

    yrc_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (terms),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (sums)
    );

    yrc_clamp_stage u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (sums),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (rgb)
    );

    assign red_first     = rgb.red_first;
    assign green_first   = rgb.green_first;
    assign blue_first    = rgb.blue_first;
    assign red_second    = rgb.red_second;
    assign green_second  = rgb.green_second;
    assign blue_second   = rgb.blue_second;
    assign frame_end_out = rgb.frame_end;

    // an empty output register lets the whole pipe move
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_s2_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && !out_valid |=> out_valid)
        else $error("stage two beat did not reach output register");

    a_in_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid)
        else $error("accepted beat missing from stage one");

endmodule
